FILE: rtl/tmb_pkg.sv
// Shared constants and types for the temporal median background block.
`timescale 1ns / 1ps
package tmb_pkg;

  localparam int HIST_DEPTH        = 5;
  localparam int MAX_FRAME_BYTES   = 1048576;
  localparam int SAMPLE_W          = 8;
  localparam int FRAME_BYTES_W     = 21;
  localparam int FRAME_BYTES_RESET = 921600;

  localparam int HIST_W    = SAMPLE_W * HIST_DEPTH;
  localparam int MED_RANK  = HIST_DEPTH / 2;
  localparam int RANK_W    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int ADDR_W    = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
  localparam int SIZE_W    = (FRAME_BYTES_W > $clog2(MAX_FRAME_BYTES + 1)) ?
                             FRAME_BYTES_W : $clog2(MAX_FRAME_BYTES + 1);
  localparam int FS_W      = $clog2(HIST_DEPTH + 2);
  localparam int FS_FULL   = HIST_DEPTH + 1;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [0:0] REG_FRAME_BYTES = 1'b0;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [HIST_W-1:0]   hist_t;
  typedef logic [ADDR_W-1:0]   addr_t;

endpackage

FILE: rtl/tmb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/tmb_median.sv
// Rank selector: picks the middle element of one history word.
`timescale 1ns / 1ps
module tmb_median import tmb_pkg::*; (
  input  hist_t   hist,
  output sample_t median
);

  sample_t            vals [HIST_DEPTH];
  logic [RANK_W-1:0]  rank [HIST_DEPTH];

  always_comb begin
    for (int i = 0; i < HIST_DEPTH; i++) begin
      vals[i] = hist[i*SAMPLE_W +: SAMPLE_W];
    end
  end

  // stable rank: ties are ordered by slot
  always_comb begin
    for (int i = 0; i < HIST_DEPTH; i++) begin
      rank[i] = '0;
      for (int j = 0; j < HIST_DEPTH; j++) begin
        if (j != i) begin
          if ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i))) begin
            rank[i] = rank[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    median = '0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      if (rank[i] == RANK_W'(MED_RANK)) begin
        median = median | vals[i];
      end
    end
  end

endmodule

FILE: rtl/temporal_median_background.sv
// Top level: per-position history update and median output stream.
//
//   channel   dir  beat contents
//   s_*       in   tdata[7:0] sample, tuser frame_start
//   m_*       out  tdata[7:0] background, tuser background_valid, tlast frame_last
//   apb       in   offset 0x0 frame_bytes (21 bits)
//
// One beat per clock unless the output stalls; beats pass the s1 and output registers.
// The history RAM read issues on accept; update and write-back happen when s1 advances,
// with the just-written word forwarded when consecutive beats hit the same position.
// History RAM contents are undefined after reset; no clearing pass is made.
// A stalled output holds the pipeline and drops s_tready once s1 holds a beat.
`timescale 1ns / 1ps
module temporal_median_background import tmb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] sample
  input  logic                  s_tuser,   // [0] frame_start
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [7:0] background
  output logic                  m_tuser,   // [0] background_valid
  output logic                  m_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [FRAME_BYTES_W-1:0] frame_bytes;
  logic [SIZE_W-1:0]        eff_size;
  logic [SIZE_W-1:0]        eff_size_next;
  logic [FRAME_BYTES_W-1:0] wr_bytes;
  logic                     cfg_wr;

  addr_t                    position;
  addr_t                    position_next;
  logic [FS_W-1:0]          frames_seen;
  logic [FS_W-1:0]          frames_seen_next;

  logic                     accept;
  addr_t                    pos_in;
  logic [SIZE_W-1:0]        pos_inc;
  logic                     last_in;

  logic                     s1_valid;
  logic                     s1_adv;
  addr_t                    s1_pos;
  sample_t                  s1_sample;
  logic                     s1_bg_valid;
  logic                     s1_last;
  logic                     s1_fwd;
  hist_t                    fwd_word;
  hist_t                    rd_word;
  hist_t                    old_word;
  hist_t                    new_word;
  sample_t                  median;

  // configuration
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_FRAME_BYTES);
  assign wr_bytes = pwdata[FRAME_BYTES_W-1:0];
  assign prdata   = (paddr[2] == REG_FRAME_BYTES) ?
                    APB_DATA_W'(frame_bytes) : '0;

  always_comb begin
    if (wr_bytes == '0) begin
      eff_size_next = SIZE_W'(1);
    end else if (SIZE_W'(wr_bytes) > SIZE_W'(MAX_FRAME_BYTES)) begin
      eff_size_next = SIZE_W'(MAX_FRAME_BYTES);
    end else begin
      eff_size_next = SIZE_W'(wr_bytes);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bytes <= FRAME_BYTES_W'(FRAME_BYTES_RESET);
      eff_size    <= SIZE_W'(FRAME_BYTES_RESET);
    end else if (cfg_wr) begin
      frame_bytes <= wr_bytes;
      eff_size    <= eff_size_next;
    end
  end

  // input stage
  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  assign pos_in   = s_tuser ? '0 : position;
  assign pos_inc  = SIZE_W'(pos_in) + SIZE_W'(1);
  assign last_in  = pos_inc >= eff_size;

  always_comb begin
    position_next    = last_in ? '0 : ADDR_W'(pos_inc);
    frames_seen_next = frames_seen;
    if ((pos_in == '0) && (frames_seen < FS_W'(FS_FULL))) begin
      frames_seen_next = frames_seen + FS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      frames_seen <= '0;
      s1_valid    <= 1'b0;
    end else begin
      if (accept) begin
        position    <= position_next;
        frames_seen <= frames_seen_next;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos      <= pos_in;
      s1_sample   <= s_tdata;
      s1_bg_valid <= frames_seen_next >= FS_W'(FS_FULL);
      s1_last     <= last_in;
      s1_fwd      <= s1_adv && (s1_pos == pos_in);
    end
    if (s1_adv) begin
      fwd_word <= new_word;
    end
  end

  tmb_ram #(
    .WIDTH (HIST_W),
    .DEPTH (MAX_FRAME_BYTES)
  ) u_hist_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_pos),
    .wdata (new_word),
    .re    (accept),
    .raddr (pos_in),
    .rdata (rd_word)
  );

  // update stage: shift the new byte in, drop the oldest
  assign old_word = s1_fwd ? fwd_word : rd_word;
  assign new_word = {old_word[HIST_W-SAMPLE_W-1:0], s1_sample};

  tmb_median u_median (
    .hist   (new_word),
    .median (median)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= s1_bg_valid ? median : '0;
      m_tuser <= s1_bg_valid;
      m_tlast <= s1_last;
    end
  end

endmodule

FILE: rtl/tmb_checker.sv
// Port-level checker for the temporal median background block, bound to the top level.
`timescale 1ns / 1ps
module tmb_checker import tmb_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [7:0]            m_tdata,
  input logic                  m_tuser,
  input logic                  m_tlast,
  input logic                  pready
);

  a_bg_zero_when_invalid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("background nonzero while not valid");

  a_valid_sticks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tuser) |=> !(m_tvalid && !m_tuser))
    else $error("background valid fell without reset");

  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output beat right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) &&
                                 $stable(m_tuser) && $stable(m_tlast)))
    else $error("stalled output beat changed");

  a_pready_high: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

endmodule

bind temporal_median_background tmb_checker u_tmb_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast),
  .pready   (pready)
);
